/* rtl/core/encoder_velocity_pid_defines.svh */
// Assertion macros used by the encoder velocity PID top level.
`ifndef ENCODER_VELOCITY_PID_DEFINES_SVH
`define ENCODER_VELOCITY_PID_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EVPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EVPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/evpid_pkg.sv */
// Shared types and constants for the encoder velocity PID block.
package evpid_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_LOOP  = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_DERIV_GAIN = 3'd3,
    REG_ENC_SCALE  = 3'd4,
    REG_PWM_SCALE  = 3'd5
  } cfg_reg_t;

  // Bit-serial multiplier: multiplicand x multiplier -> product
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Bit-serial divider: dividend / divisor -> quotient
  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Command limit and the Q32.32 integer part at which a command clips
  localparam logic [9:0]  CMD_LIMIT  = 10'd400;
  localparam logic [47:0] CLIP_LEVEL = 48'd401;

  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic signed [31:0] target_velocity;
    logic        [15:0] elapsed_us;
  } evpid_in_t;

  typedef struct packed {
    logic signed [9:0] motor_command;
    logic              clipped;
  } evpid_out_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } evpid_unit_sts_t;

endpackage

/* rtl/core/encoder_velocity_pid.sv */
// Encoder velocity PID controller: top level with sequencer, state and config registers.
//
// One request in, one command out. Velocity is the count delta times enc_scale
// over elapsed_us; error, saturating 48-bit error integral and derivative feed
// three gain terms whose sum, times pwm_scale, gives a command saturated to
// +-400 (clipped flags saturation). All arithmetic goes through one bit-serial
// multiplier and one bit-serial divider, used in turn. Closed loop: six products
// and two quotients per request. Open loop: one product. A new request is taken
// as soon as the sequencer is back in idle, even while the previous command
// still waits on out_stall.
`include "encoder_velocity_pid_defines.svh"

module encoder_velocity_pid (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  evpid_pkg::evpid_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output evpid_pkg::evpid_out_t               out_data,
  input  logic                                cfg_we,
  input  logic [evpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [evpid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW = evpid_pkg::MUL_A_W;
  localparam int BW = evpid_pkg::MUL_B_W;
  localparam int PW = evpid_pkg::MUL_P_W;
  localparam int NW = evpid_pkg::DIV_N_W;
  localparam int CNW = evpid_pkg::DIV_CNT_W;

  localparam logic [60:0] TERM_LIMIT = {1'b1, 60'b0};

  typedef enum logic [3:0] {
    S_IDLE,
    S_VEL_MUL,
    S_VEL_DIV,
    S_ISUM_MUL,
    S_DER_DIV,
    S_P_TERM,
    S_I_TERM,
    S_D_TERM,
    S_CMD_MUL,
    S_DONE
  } state_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [47:0] abs48(input logic [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  function automatic logic [62:0] abs63(input logic [62:0] v);
    return v[62] ? (~v + 63'd1) : v;
  endfunction

  // Config and architectural state
  logic        open_loop_r;
  logic [31:0] prop_gain_r;
  logic [31:0] integ_gain_r;
  logic [31:0] deriv_gain_r;
  logic [31:0] enc_scale_r;
  logic [31:0] pwm_scale_r;
  logic [31:0] last_count_r;
  logic [31:0] last_error_r;
  logic [47:0] error_sum_r;

  // Sequencer and per-request working registers
  state_t      state_r;
  logic        run_r;
  logic        out_valid_r;
  evpid_pkg::evpid_out_t out_data_r;
  logic [31:0] target_r;
  logic [15:0] dt_r;
  logic [31:0] diff_mag_r;
  logic        diff_neg_r;
  logic [31:0] err_r;
  logic        dneg_r;
  logic [32:0] deriv_mag_r;
  logic [62:0] sum_r;

  // Arithmetic unit hookup
  logic                        mul_start;
  logic [AW-1:0]               mul_a;
  logic [BW-1:0]               mul_b;
  logic [PW-1:0]               mul_prod;
  evpid_pkg::evpid_unit_sts_t  mul_sts;
  logic                        div_start;
  logic [NW-1:0]               div_dvd;
  logic [CNW-1:0]              div_nbits;
  logic [NW-1:0]               div_quot;
  evpid_pkg::evpid_unit_sts_t  div_sts;

  // Combinational datapath
  logic        in_fire;
  logic        out_free;
  logic        unit_done;
  logic [31:0] cnt_diff;
  logic [32:0] err_diff;
  logic [31:0] vel;
  logic [32:0] err_wide;
  logic [31:0] err_nxt;
  logic [48:0] isum_term;
  logic [48:0] isum_wide;
  logic [47:0] isum_nxt;
  logic [63:0] term_raw;
  logic [60:0] term_mag;
  logic        term_neg;
  logic [62:0] term_ext;
  logic [62:0] sum_nxt;
  logic [62:0] cmd_src;
  logic [40:0] cmd_mag;
  logic [47:0] cmd_int;
  logic        cmd_clip;
  logic [8:0]  cmd_abs;
  logic [9:0]  cmd_val;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign unit_done = mul_sts.done || div_sts.done;
  assign cnt_diff  = in_data.encoder_count - last_count_r;
  assign err_diff  = {err_r[31], err_r} - {last_error_r[31], last_error_r};

  // Unit operands by sequencer step
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_nbits = '0;
    unique case (state_r)
      S_VEL_MUL: begin
        mul_start = !run_r;
        mul_a     = AW'(diff_mag_r);
        mul_b     = enc_scale_r;
      end
      S_VEL_DIV: begin
        div_start = !run_r;
        div_dvd   = mul_prod[NW-1:0];
        div_nbits = CNW'(NW);
      end
      S_ISUM_MUL: begin
        mul_start = !run_r;
        mul_a     = AW'(abs32(err_r));
        mul_b     = BW'(dt_r);
      end
      S_DER_DIV: begin
        // |delta| left-justified so only its 33 bits are divided
        div_start = !run_r;
        div_dvd   = {abs33(err_diff), 31'b0};
        div_nbits = CNW'(33);
      end
      S_P_TERM: begin
        mul_start = !run_r;
        mul_a     = AW'(abs32(err_r));
        mul_b     = prop_gain_r;
      end
      S_I_TERM: begin
        mul_start = !run_r;
        mul_a     = abs48(error_sum_r);
        mul_b     = integ_gain_r;
      end
      S_D_TERM: begin
        mul_start = !run_r;
        mul_a     = AW'(deriv_mag_r);
        mul_b     = deriv_gain_r;
      end
      S_CMD_MUL: begin
        mul_start = !run_r;
        mul_a     = AW'(cmd_mag);
        mul_b     = pwm_scale_r;
      end
      default: begin
      end
    endcase
  end

  // Velocity and error, saturated to 32 bits
  always_comb begin
    if (|div_quot[NW-1:31]) begin
      vel = diff_neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      vel = diff_neg_r ? (~{1'b0, div_quot[30:0]} + 32'd1) : {1'b0, div_quot[30:0]};
    end
    err_wide = {target_r[31], target_r} - {vel[31], vel};
    if (err_wide[32] != err_wide[31]) begin
      err_nxt = err_wide[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      err_nxt = err_wide[31:0];
    end
  end

  // Error integral, saturated to 48 bits
  always_comb begin
    isum_term = err_r[31] ? (~{2'b0, mul_prod[46:0]} + 49'd1) : {2'b0, mul_prod[46:0]};
    isum_wide = {error_sum_r[47], error_sum_r} + isum_term;
    if (isum_wide[48] != isum_wide[47]) begin
      isum_nxt = isum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      isum_nxt = isum_wide[47:0];
    end
  end

  // Gain term: Q32.32 product back to Q16.16, magnitude capped at 2^60
  always_comb begin
    term_raw = mul_prod[79:16];
    if ((|term_raw[63:61]) || (term_raw[60] && (|term_raw[59:0]))) begin
      term_mag = TERM_LIMIT;
    end else begin
      term_mag = term_raw[60:0];
    end
    priority case (state_r)
      S_P_TERM: term_neg = err_r[31];
      S_I_TERM: term_neg = error_sum_r[47];
      default:  term_neg = dneg_r;
    endcase
    term_ext = term_neg ? (~{2'b0, term_mag} + 63'd1) : {2'b0, term_mag};
    sum_nxt  = sum_r + term_ext;
  end

  // Command: anything at or above 2^41 clips for any nonzero scale
  always_comb begin
    cmd_src  = abs63(sum_r);
    cmd_mag  = (|cmd_src[62:41]) ? {41{1'b1}} : cmd_src[40:0];
    cmd_int  = mul_prod[79:32];
    cmd_clip = (cmd_int >= evpid_pkg::CLIP_LEVEL);
    cmd_abs  = cmd_clip ? evpid_pkg::CMD_LIMIT[8:0] : cmd_int[8:0];
    cmd_val  = sum_r[62] ? (~{1'b0, cmd_abs} + 10'd1) : {1'b0, cmd_abs};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      open_loop_r  <= 1'b0;
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      enc_scale_r  <= '0;
      pwm_scale_r  <= '0;
      last_count_r <= '0;
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          evpid_pkg::REG_OPEN_LOOP:  open_loop_r  <= cfg_wdata[0];
          evpid_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
          evpid_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
          evpid_pkg::REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
          evpid_pkg::REG_ENC_SCALE:  enc_scale_r  <= cfg_wdata;
          evpid_pkg::REG_PWM_SCALE:  pwm_scale_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // new command loads as the held one leaves
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            target_r     <= in_data.target_velocity;
            dt_r         <= (in_data.elapsed_us == '0) ? 16'd1 : in_data.elapsed_us;
            diff_mag_r   <= abs32(cnt_diff);
            diff_neg_r   <= cnt_diff[31];
            last_count_r <= in_data.encoder_count;
            if (open_loop_r) begin
              sum_r   <= {{31{in_data.target_velocity[31]}}, in_data.target_velocity};
              state_r <= S_CMD_MUL;
            end else begin
              sum_r   <= '0;
              state_r <= S_VEL_MUL;
            end
          end
        end
        S_VEL_MUL: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r   <= 1'b0;
            state_r <= S_VEL_DIV;
          end
        end
        S_VEL_DIV: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r   <= 1'b0;
            err_r   <= err_nxt;
            state_r <= S_ISUM_MUL;
          end
        end
        S_ISUM_MUL: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r       <= 1'b0;
            error_sum_r <= isum_nxt;
            state_r     <= S_DER_DIV;
          end
        end
        S_DER_DIV: begin
          if (!run_r) begin
            run_r  <= 1'b1;
            dneg_r <= err_diff[32];
          end else if (unit_done) begin
            run_r        <= 1'b0;
            deriv_mag_r  <= div_quot[32:0];
            last_error_r <= err_r;
            state_r      <= S_P_TERM;
          end
        end
        S_P_TERM: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r   <= 1'b0;
            sum_r   <= sum_nxt;
            state_r <= S_I_TERM;
          end
        end
        S_I_TERM: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r   <= 1'b0;
            sum_r   <= sum_nxt;
            state_r <= S_D_TERM;
          end
        end
        S_D_TERM: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r   <= 1'b0;
            sum_r   <= sum_nxt;
            state_r <= S_CMD_MUL;
          end
        end
        S_CMD_MUL: begin
          if (!run_r) begin
            run_r <= 1'b1;
          end else if (unit_done) begin
            run_r   <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // product stays in the multiplier until the next start
          if (out_free) begin
            out_data_r.motor_command <= cmd_val;
            out_data_r.clipped       <= cmd_clip;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  evpid_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  evpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (dt_r),
    .nbits    (div_nbits),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  `EVPID_ASSERT_IMP(a_mul_start_free, mul_start, !mul_sts.busy && !mul_sts.done, "multiplier restarted while busy")
  `EVPID_ASSERT_IMP(a_div_start_free, div_start, !div_sts.busy && !div_sts.done, "divider restarted while busy")
  `EVPID_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state_r) == S_DONE, "result raised outside done step")
  `EVPID_ASSERT_IMP(a_clip_at_limit, out_valid && out_data.clipped, out_data.motor_command == 10'sd400 || out_data.motor_command == -10'sd400, "clipped command not at limit")

endmodule

/* rtl/core/evpid_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module evpid_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [evpid_pkg::MUL_A_W-1:0]     a,
  input  logic [evpid_pkg::MUL_B_W-1:0]     b,
  output evpid_pkg::evpid_unit_sts_t        sts,
  output logic [evpid_pkg::MUL_P_W-1:0]     prod
);

  localparam int AW = evpid_pkg::MUL_A_W;
  localparam int BW = evpid_pkg::MUL_B_W;
  localparam int PW = evpid_pkg::MUL_P_W;
  localparam int CW = evpid_pkg::MUL_CNT_W;

  logic [PW-1:0] acc_r;
  logic [AW-1:0] a_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [AW-1:0] addend;
  logic [AW:0]   hi_sum;
  logic [PW-1:0] acc_nxt;

  // Multiplier sits in the low half and shifts out as the product shifts in.
  always_comb begin
    addend  = acc_r[0] ? a_r : '0;
    hi_sum  = {1'b0, acc_r[PW-1:BW]} + {1'b0, addend};
    acc_nxt = {hi_sum, acc_r[BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {{AW{1'b0}}, b};
      a_r   <= a;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

/* rtl/core/evpid_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle from the dividend MSB.
module evpid_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [evpid_pkg::DIV_N_W-1:0]       dividend,
  input  logic [evpid_pkg::DIV_D_W-1:0]       divisor,
  input  logic [evpid_pkg::DIV_CNT_W-1:0]     nbits,
  output evpid_pkg::evpid_unit_sts_t          sts,
  output logic [evpid_pkg::DIV_N_W-1:0]       quot
);

  localparam int NW = evpid_pkg::DIV_N_W;
  localparam int DW = evpid_pkg::DIV_D_W;
  localparam int CW = evpid_pkg::DIV_CNT_W;

  logic [NW-1:0] dvd_r;
  logic [DW-1:0] dsr_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          q_bit;

  always_comb begin
    trial     = {rem_r, dvd_r[NW-1]};
    trial_sub = trial - {1'b0, dsr_r};
    q_bit     = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NW-2:0], 1'b0};
      rem_r <= q_bit ? trial_sub[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], q_bit};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quo_r;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the encoder velocity PID controller.
`timescale 1ns / 100ps

module testbench;

  localparam logic [evpid_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [evpid_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint unsigned TERM_CAP = 64'h1000_0000_0000_0000;
  localparam longint unsigned VEL_CAP  = 64'h0000_0001_0000_0000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 183;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    bit          open;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [31:0] enc;
    logic [31:0] pwm;
  } tuning_t;

  typedef struct {
    int                    tune;
    evpid_pkg::evpid_in_t  req;
    bit                    typed;
    evpid_pkg::evpid_out_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  evpid_pkg::evpid_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  evpid_pkg::evpid_out_t out_data;
  logic cfg_we = 1'b0;
  logic [evpid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [evpid_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // controller model state and settings
  bit          open_sel;
  logic [31:0] kp, ki, kd, counts_scale, pwm_gain;
  logic [31:0] prev_count;
  longint      prev_error;
  longint      err_integral;

  evpid_pkg::evpid_out_t expected_cmds[$];
  vector_t    directed[$];
  tuning_t    presets[4];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         steady_phase = 1'b0;

  encoder_velocity_pid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("encoder_velocity_pid test failed");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Q16.16 gain times Q16.16 operand, truncated toward zero, capped at 2^60
  function automatic longint scaled_term(logic [31:0] gain, longint x);
    longint unsigned m, g, p;
    m = mag(x);
    g = {32'd0, gain};
    p = g * (m >> 16) + ((g * (m & 64'hFFFF)) >> 16);
    if (p > TERM_CAP) p = TERM_CAP;
    return (x < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic evpid_pkg::evpid_out_t pwm_command(longint s);
    longint unsigned m, g, r, ceiling;
    logic [9:0] r10;
    evpid_pkg::evpid_out_t res;
    res = '0;
    m = mag(s);
    g = {32'd0, pwm_gain};
    if (pwm_gain == 0 || m == 0) return res;
    ceiling = ((longint'(evpid_pkg::CLIP_LEVEL) << 32) - 1) / g;
    if (m > ceiling) begin
      r = {54'd0, evpid_pkg::CMD_LIMIT};
      res.clipped = 1'b1;
    end else begin
      r = (m * g) >> 32;
    end
    r10 = r[9:0];
    res.motor_command = (s < 0) ? -r10 : r10;
    return res;
  endfunction

  // advances the controller state by one request and returns its command
  function automatic evpid_pkg::evpid_out_t predict_command(evpid_pkg::evpid_in_t req);
    longint dt, diff, vel, err, deriv, sum, target;
    longint unsigned vm;
    logic [31:0] delta;
    evpid_pkg::evpid_out_t res;
    dt = (req.elapsed_us == 0) ? 64'sd1 : {48'd0, req.elapsed_us};
    target = longint'($signed(req.target_velocity));
    if (open_sel) begin
      res = pwm_command(target);
    end else begin
      delta = req.encoder_count - prev_count;
      diff = longint'($signed(delta));
      vm = mag(diff) * {32'd0, counts_scale} / dt;
      if (vm > VEL_CAP) vm = VEL_CAP;
      vel = clamp32((diff < 0) ? -longint'(vm) : longint'(vm));
      err = clamp32(target - vel);
      err_integral = err_integral + err * dt;
      if (err_integral > INTEG_MAX) err_integral = INTEG_MAX;
      if (err_integral < INTEG_MIN) err_integral = INTEG_MIN;
      deriv = (err - prev_error) / dt;
      sum = scaled_term(kp, err) + scaled_term(ki, err_integral) + scaled_term(kd, deriv);
      res = pwm_command(sum);
      prev_error = err;
    end
    prev_count = req.encoder_count;
    return res;
  endfunction

  task automatic set_reg(logic [evpid_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    unique case (idx)
      evpid_pkg::REG_OPEN_LOOP:  open_sel = value[0];
      evpid_pkg::REG_PROP_GAIN:  kp = value;
      evpid_pkg::REG_INTEG_GAIN: ki = value;
      evpid_pkg::REG_DERIV_GAIN: kd = value;
      evpid_pkg::REG_ENC_SCALE:  counts_scale = value;
      evpid_pkg::REG_PWM_SCALE:  pwm_gain = value;
      default: ;
    endcase
  endtask

  task automatic apply_tuning(tuning_t t);
    logic [31:0] spare;
    spare = $urandom;
    // upper bits of the mode register must be ignored
    set_reg(evpid_pkg::REG_OPEN_LOOP, {spare[31:1], t.open});
    set_reg(evpid_pkg::REG_PROP_GAIN, t.kp);
    set_reg(REG_UNUSED_A, $urandom);
    set_reg(evpid_pkg::REG_INTEG_GAIN, t.ki);
    set_reg(evpid_pkg::REG_DERIV_GAIN, t.kd);
    set_reg(evpid_pkg::REG_ENC_SCALE, t.enc);
    set_reg(REG_UNUSED_B, $urandom);
    set_reg(evpid_pkg::REG_PWM_SCALE, t.pwm);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_cmds.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_request(evpid_pkg::evpid_in_t req, bit typed,
                              evpid_pkg::evpid_out_t want);
    int gap;
    evpid_pkg::evpid_out_t predicted;
    gap = steady_phase ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_command(req);
    expected_cmds.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(int tune, logic [31:0] count, logic [31:0] target, logic [15:0] dt,
                         bit typed, logic [9:0] cmd, bit clip);
    vector_t row;
    row.tune = tune;
    row.req = '{count, target, dt};
    row.typed = typed;
    row.want = '{cmd, clip};
    directed.push_back(row);
  endtask

  function automatic tuning_t random_tuning(int kind);
    tuning_t t;
    t.open = (kind == 1);
    t.kp  = $urandom_range(0, 1 << 18);
    t.ki  = $urandom_range(0, 64);
    t.kd  = $urandom_range(0, 1 << 24);
    t.enc = $urandom_range(0, 1 << 22);
    t.pwm = $urandom_range(1 << 14, 1 << 18);
    if (kind == 2) begin
      t.open = $urandom_range(0, 1);
      t.kp = $urandom; t.ki = $urandom; t.kd = $urandom;
      t.enc = $urandom; t.pwm = $urandom;
    end else if (kind == 3) begin
      t.kp  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      t.ki  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      t.kd  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      t.enc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
      t.pwm = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
    end
    return t;
  endfunction

  // command sink: random back-pressure, checks each command in order
  initial begin : sink
    int hold;
    evpid_pkg::evpid_out_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = steady_phase ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none got %0d clipped %0b",
                 $time, $signed(out_data.motor_command), out_data.clipped);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_data.motor_command !== want.motor_command) begin
          $display("%0t: motor_command expected %0d got %0d", $time,
                   $signed(want.motor_command), $signed(out_data.motor_command));
          mismatches++;
        end
        if (out_data.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b got %0b", $time, want.clipped,
                   out_data.clipped);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int active_tune, p, kind, choice, step, pick;
    vector_t row;
    evpid_pkg::evpid_in_t req;
    logic [31:0] shaft_pos, speed_ref;

    open_sel = 0; kp = 0; ki = 0; kd = 0; counts_scale = 0; pwm_gain = 0;
    prev_count = 0; prev_error = 0; err_integral = 0;

    presets[0] = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    presets[1] = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000};
    presets[2] = '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF};
    presets[3] = '{1'b0, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000};

    // reset values: zero pwm_scale gives zero commands, zero elapsed included
    add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1,     1, 10'sd0, 0);
    add_row(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF,  1, 10'sd0, 0);
    add_row(0, 32'd0,         32'd0,         16'd0,     1, 10'sd0, 0);
    add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,  1, 10'sd0, 0);
    // open loop with unity pwm_scale: command is the integer part of target
    add_row(1, 32'd123,       32'h0005_0000, 16'd10,    1, 10'sd5, 0);
    add_row(1, 32'd124,       32'hFFF9_0001, 16'd10,    1, -10'sd6, 0);
    add_row(1, 32'd125,       32'h0190_0000, 16'd0,     1, 10'sd400, 0);
    add_row(1, 32'd126,       32'h0191_0000, 16'd1,     1, 10'sd400, 1);
    add_row(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,  1, 10'sd400, 1);
    add_row(1, 32'h8000_0000, 32'h8000_0000, 16'd7,     1, -10'sd400, 1);
    add_row(1, 32'd0,         32'h0000_FFFF, 16'd7,     1, 10'sd0, 0);
    add_row(1, 32'd0,         32'hFE70_0000, 16'd7,     1, -10'sd400, 0);
    // everything at its maximum: velocity cap, integral saturation, huge terms
    add_row(2, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1,     0, 10'sd0, 0);
    add_row(2, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1,     0, 10'sd0, 0);
    add_row(2, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF,  0, 10'sd0, 0);
    add_row(2, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF,  0, 10'sd0, 0);
    add_row(2, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF,  0, 10'sd0, 0);
    add_row(2, 32'd0,         32'h8000_0000, 16'hFFFF,  0, 10'sd0, 0);
    add_row(2, 32'd0,         32'h8000_0000, 16'hFFFF,  0, 10'sd0, 0);
    add_row(2, 32'd0,         32'h8000_0000, 16'd0,     0, 10'sd0, 0);
    add_row(3, 32'd1000,      32'h0002_0000, 16'd500,   0, 10'sd0, 0);
    add_row(3, 32'd1500,      32'h0002_0000, 16'd500,   0, 10'sd0, 0);
    add_row(3, 32'd1200,      32'hFFFD_0000, 16'd250,   0, 10'sd0, 0);
    add_row(3, 32'd1200,      32'd0,         16'd0,     0, 10'sd0, 0);
    add_row(3, 32'hFFFF_EC78, 32'h0001_0000, 16'hFFFF,  0, 10'sd0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    active_tune = 0;
    foreach (directed[i]) begin
      row = directed[i];
      if (row.tune != active_tune) begin
        drain_results();
        apply_tuning(presets[row.tune]);
        active_tune = row.tune;
      end
      send_request(row.req, row.typed, row.want);
    end

    shaft_pos = $urandom;
    speed_ref = 32'd0;
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      kind = p % 4;
      apply_tuning(random_tuning(kind));
      steady_phase = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        choice = $urandom_range(0, 99);
        if (choice < 10) begin
          req = '{$urandom, $urandom, 16'($urandom)};
        end else begin
          step = $urandom_range(0, 6000) - 3000;
          shaft_pos = shaft_pos + step;
          if ($urandom_range(0, 9) == 0)
            speed_ref = $urandom_range(0, 1 << 24) - (1 << 23);
          req = '{shaft_pos, speed_ref, 16'($urandom_range(50, 3000))};
          if (choice < 16) begin
            pick = $urandom_range(0, 2);
            req.elapsed_us = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : 16'hFFFF;
          end
        end
        send_request(req, 1'b0, '0);
        // occasionally let the controller run dry before the next request
        if ($urandom_range(0, 59) == 0) drain_results();
      end
    end

    drain_results();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("encoder_velocity_pid test passed");
    end else begin
      $display("encoder_velocity_pid test failed");
    end
    $finish;
  end

endmodule
